// ----- rtl/grey_quantize_frame_bitplane_packer_top_macros.svh -----
// ----------------------------------------------------------------------------
// gqp assertion macros
// concurrent assertion helpers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef GREY_QUANTIZE_FRAME_BITPLANE_PACKER_TOP_MACROS_SVH
`define GREY_QUANTIZE_FRAME_BITPLANE_PACKER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// ante implies cons on the same edge
`define GQP_ASSERT_IMPL(lbl, clk_i, rstn_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
		else $error("gqp assertion failed");

// cond never holds
`define GQP_ASSERT_NEVER(lbl, clk_i, rstn_i, cond) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) !(cond)) \
		else $error("gqp assertion failed");

`else

`define GQP_ASSERT_IMPL(lbl, clk_i, rstn_i, ante, cons)
`define GQP_ASSERT_NEVER(lbl, clk_i, rstn_i, cond)

`endif

`endif

// ----- rtl/gqp_pkg.sv -----
// ----------------------------------------------------------------------------
// gqp_pkg
// shared constants and types of the grey quantizer and bitplane packer
// ----------------------------------------------------------------------------
package gqp_pkg;

	// image geometry
	localparam int IMAGE_WIDTH  = 48;
	localparam int IMAGE_HEIGHT = 32;
	localparam int ROW_BYTES    = (IMAGE_WIDTH + 7) / 8;
	localparam int GROUP_W      = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
	localparam int X_W          = GROUP_W + 3;
	localparam int STORE_DEPTH  = IMAGE_WIDTH * IMAGE_HEIGHT;
	localparam int ADDR_W       = $clog2(STORE_DEPTH);

	// field widths
	localparam int RGBA_W  = 32;
	localparam int ROW_W   = 5;
	localparam int COL_W   = 6;
	localparam int FRAME_W = 8;
	localparam int GREY_W  = 8;

	// emit threshold: grey*(F+1) <= 255*(F-f)
	localparam int THRESH_W = 16;
	localparam int SCALE_W  = 9;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NUM_FRAMES  = 1'b0,
		REG_INVERT_ROWS = 1'b1
	} cfg_reg_t;

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_EMIT = 1'b1;

	typedef struct packed {
		logic               mode;
		logic [RGBA_W-1:0]  pixel_rgba;
		logic [ROW_W-1:0]   row_number;
		logic [COL_W-1:0]   column_number;
		logic [FRAME_W-1:0] frame_number;
	} req_item_t;

	typedef struct packed {
		logic [7:0] packed_byte;
		logic       last_of_row;
	} res_item_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [GREY_W-1:0] data;
	} store_wr_t;

	typedef struct packed {
		logic                start;
		logic [ROW_W-1:0]    row;
		logic [THRESH_W-1:0] thresh;
		logic [SCALE_W-1:0]  scale;
	} emit_req_t;

endpackage

// ----- rtl/gqp_grey.sv -----
// ----------------------------------------------------------------------------
// gqp_grey
// rgba to grey: shared multiplier for the weighted squares, then a
// digit-by-digit square root, one result bit per cycle
// ----------------------------------------------------------------------------
module gqp_grey (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [gqp_pkg::RGBA_W-1:0]  rgba,
	output logic                        done,
	output logic [gqp_pkg::GREY_W-1:0]  grey
);

	localparam logic [1:0] CH_RED   = 2'd0;
	localparam logic [1:0] CH_GREEN = 2'd1;
	localparam logic [1:0] CH_BLUE  = 2'd2;

	// q16 weights, they sum to 65536
	localparam logic [15:0] W_RED   = 16'd19595;
	localparam logic [15:0] W_GREEN = 16'd38470;
	localparam logic [15:0] W_BLUE  = 16'd7471;

	typedef enum logic [4:0] {
		G_IDLE = 5'b00001,
		G_SQ   = 5'b00010,
		G_WT   = 5'b00100,
		G_ACC  = 5'b01000,
		G_ROOT = 5'b10000
	} gstate_t;

	gstate_t     state_q;
	logic [1:0]  ch_q;
	logic [3:0]  step_q;
	logic        done_q;
	logic [23:0] rgb_q;
	logic [15:0] sq_q;
	logic [31:0] prod_q;
	logic [31:0] acc_q;
	logic [31:0] rad_q;
	logic [17:0] rem_q;
	logic [15:0] root_q;
	logic [7:0]  grey_q;

	logic [7:0]  chan;
	logic [15:0] weight;
	logic [19:0] rem_sh;
	logic [19:0] trial;
	logic        take;
	logic [15:0] root_nx;
	logic [17:0] rem_nx;

	always_comb begin
		case (ch_q)
			CH_RED: begin
				chan   = rgb_q[23:16];
				weight = W_RED;
			end
			CH_GREEN: begin
				chan   = rgb_q[15:8];
				weight = W_GREEN;
			end
			default: begin
				chan   = rgb_q[7:0];
				weight = W_BLUE;
			end
		endcase
	end

	// one root digit: bring down two radicand bits, try 4*root+1
	assign rem_sh  = {rem_q, rad_q[31:30]};
	assign trial   = {2'b00, root_q, 2'b01};
	assign take    = (rem_sh >= trial);
	assign root_nx = {root_q[14:0], take};
	assign rem_nx  = take ? 18'(rem_sh - trial) : rem_sh[17:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= G_IDLE;
			ch_q    <= CH_RED;
			step_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				G_IDLE: begin
					if (start) begin
						if (!rgba[7]) begin
							done_q <= 1'b1;
						end else begin
							ch_q    <= CH_RED;
							state_q <= G_SQ;
						end
					end
				end
				G_SQ: state_q <= G_WT;
				G_WT: state_q <= G_ACC;
				G_ACC: begin
					if (ch_q == CH_BLUE) begin
						step_q  <= '0;
						state_q <= G_ROOT;
					end else begin
						ch_q    <= ch_q + 2'd1;
						state_q <= G_SQ;
					end
				end
				G_ROOT: begin
					step_q <= step_q + 4'd1;
					if (step_q == 4'd15) begin
						done_q  <= 1'b1;
						state_q <= G_IDLE;
					end
				end
				default: state_q <= G_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			G_IDLE: begin
				if (start) begin
					rgb_q  <= rgba[31:8];
					acc_q  <= '0;
					grey_q <= 8'hFF;
				end
			end
			G_SQ: sq_q <= 16'(chan) * 16'(chan);
			G_WT: prod_q <= 32'(sq_q) * 32'(weight);
			G_ACC: begin
				acc_q  <= acc_q + prod_q;
				rad_q  <= acc_q + prod_q;
				rem_q  <= '0;
				root_q <= '0;
			end
			G_ROOT: begin
				rad_q  <= {rad_q[29:0], 2'b00};
				rem_q  <= rem_nx;
				root_q <= root_nx;
				if (step_q == 4'd15) begin
					grey_q <= root_nx[15:8];
				end
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign grey = grey_q;

endmodule

// ----- rtl/gqp_div.sv -----
// ----------------------------------------------------------------------------
// gqp_div
// restoring divider, 16 bit dividend by 8 bit divisor, one bit per cycle
// ----------------------------------------------------------------------------
module gqp_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] dividend,
	input  logic [7:0]  divisor,
	output logic        done,
	output logic [15:0] quotient
);

	logic        busy_q;
	logic [3:0]  step_q;
	logic        done_q;
	logic [15:0] num_q;
	logic [7:0]  rem_q;
	logic [7:0]  dsr_q;

	logic [8:0]  rem_sh;
	logic        ge;
	logic [7:0]  rem_nx;

	assign rem_sh = {rem_q, num_q[15]};
	assign ge     = (rem_sh >= {1'b0, dsr_q});
	assign rem_nx = ge ? 8'(rem_sh - {1'b0, dsr_q}) : rem_sh[7:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (busy_q) begin
				step_q <= step_q + 4'd1;
				if (step_q == 4'd15) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end
		end
	end

	// quotient bits shift in where the dividend bits leave
	always_ff @(posedge clk) begin
		if (busy_q) begin
			num_q <= {num_q[14:0], ge};
			rem_q <= rem_nx;
		end else if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end
	end

	assign done     = done_q;
	assign quotient = num_q;

endmodule

// ----- rtl/gqp_snap.sv -----
// ----------------------------------------------------------------------------
// gqp_snap
// snaps a grey value to the nearer of the two frame levels around it
// ----------------------------------------------------------------------------
`include "grey_quantize_frame_bitplane_packer_top_macros.svh"

module gqp_snap (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [gqp_pkg::GREY_W-1:0]  grey,
	input  logic [7:0]                  frames,
	output logic                        done,
	output logic [gqp_pkg::GREY_W-1:0]  level
);

	typedef enum logic [7:0] {
		N_IDLE = 8'b00000001,
		N_MUL  = 8'b00000010,
		N_K    = 8'b00000100,
		N_LO   = 8'b00001000,
		N_LO_W = 8'b00010000,
		N_HI   = 8'b00100000,
		N_HI_W = 8'b01000000,
		N_PICK = 8'b10000000
	} nstate_t;

	nstate_t     state_q;
	logic        done_q;
	logic [7:0]  c_q;
	logic [7:0]  f_q;
	logic [15:0] prod_q;
	logic [7:0]  k_q;
	logic [15:0] lo_q;
	logic [15:0] hi_q;
	logic [7:0]  level_q;

	logic [16:0] k_sum;
	logic [15:0] num_lo;
	logic [15:0] num_hi;
	logic        div_start;
	logic [15:0] div_num;
	logic        div_done;
	logic [15:0] div_q;
	logic [15:0] d_lo;
	logic [15:0] d_hi;
	logic [15:0] pick;

	// floor(x/255) for a 16 bit x
	assign k_sum = 17'(prod_q) + 17'd1 + 17'(prod_q[15:8]);

	// ceil(k*255/F) and ceil((k+1)*255/F)
	assign num_lo = 16'(k_q) * 16'd255 + 16'(f_q) - 16'd1;
	assign num_hi = num_lo + 16'd255;

	assign div_start = (state_q == N_LO) || (state_q == N_HI);
	assign div_num   = (state_q == N_HI) ? num_hi : num_lo;

	gqp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (f_q),
		.done     (div_done),
		.quotient (div_q)
	);

	// ties go to the upper level
	assign d_lo = 16'(c_q) - lo_q;
	assign d_hi = hi_q - 16'(c_q);
	assign pick = (d_lo < d_hi) ? lo_q : hi_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= N_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				N_IDLE: if (start) state_q <= N_MUL;
				N_MUL:  state_q <= N_K;
				N_K:    state_q <= N_LO;
				N_LO:   state_q <= N_LO_W;
				N_LO_W: if (div_done) state_q <= N_HI;
				N_HI:   state_q <= N_HI_W;
				N_HI_W: if (div_done) state_q <= N_PICK;
				N_PICK: begin
					done_q  <= 1'b1;
					state_q <= N_IDLE;
				end
				default: state_q <= N_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			N_IDLE: begin
				if (start) begin
					c_q <= grey;
					f_q <= frames;
				end
			end
			N_MUL:  prod_q <= 16'(c_q) * 16'(f_q);
			N_K:    k_q <= k_sum[15:8];
			N_LO_W: if (div_done) lo_q <= div_q;
			N_HI_W: if (div_done) hi_q <= div_q;
			N_PICK: level_q <= (pick > 16'd255) ? 8'hFF : pick[7:0];
			default: ;
		endcase
	end

	assign done  = done_q;
	assign level = level_q;

	// the grey value lies between the two candidate levels
	`GQP_ASSERT_IMPL(a_levels_bracket, clk, arst_n, state_q == N_PICK, (lo_q <= 16'(c_q)) && (hi_q > 16'(c_q)))

endmodule

// ----- rtl/gqp_row_store.sv -----
// ----------------------------------------------------------------------------
// gqp_row_store
// grey level memory with the row read sequencer and the result register
// ----------------------------------------------------------------------------
`include "grey_quantize_frame_bitplane_packer_top_macros.svh"

module gqp_row_store (
	input  logic                clk,
	input  logic                arst_n,
	input  gqp_pkg::store_wr_t  wr,
	input  gqp_pkg::emit_req_t  emit_req,
	output logic                emit_done,
	output logic                res_valid,
	input  logic                res_ready,
	output gqp_pkg::res_item_t  res_item
);

	typedef enum logic [3:0] {
		E_IDLE = 4'b0001,
		E_READ = 4'b0010,
		E_WAIT = 4'b0100,
		E_PUSH = 4'b1000
	} estate_t;

	logic [gqp_pkg::GREY_W-1:0] grey_mem_q [gqp_pkg::STORE_DEPTH];
	logic [gqp_pkg::GREY_W-1:0] rd_data_q;

	estate_t                        em_state_q;
	logic [gqp_pkg::GROUP_W-1:0]    grp_q;
	logic [2:0]                     bit_q;
	logic [gqp_pkg::ROW_W-1:0]      row_q;
	logic [gqp_pkg::THRESH_W-1:0]   thresh_q;
	logic [gqp_pkg::SCALE_W-1:0]    scale_q;
	logic                           rv_s1;
	logic                           rin_s1;
	logic [2:0]                     rbit_s1;
	logic [7:0]                     byte_q;
	logic                           res_valid_q;
	gqp_pkg::res_item_t             res_q;

	logic [gqp_pkg::X_W-1:0]    x;
	logic                       x_in;
	logic                       rd_en;
	logic [gqp_pkg::ADDR_W-1:0] rd_addr;
	logic                       hit;
	logic                       push;
	logic                       last_grp;

	assign x       = {grp_q, bit_q};
	assign x_in    = (gqp_pkg::X_W+1)'(x) < (gqp_pkg::X_W+1)'(gqp_pkg::IMAGE_WIDTH);
	assign rd_en   = (em_state_q == E_READ) && x_in;
	assign rd_addr = gqp_pkg::ADDR_W'(row_q) * gqp_pkg::ADDR_W'(gqp_pkg::IMAGE_WIDTH)
	               + gqp_pkg::ADDR_W'(x);

	// pixel lit when grey*(F+1) <= 255*(F-f)
	assign hit = (17'(rd_data_q) * 17'(scale_q)) <= 17'(thresh_q);

	assign last_grp  = (grp_q == '0);
	assign push      = (em_state_q == E_PUSH) && (!res_valid_q || res_ready);
	assign emit_done = push && last_grp;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			grey_mem_q[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_data_q <= grey_mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			em_state_q  <= E_IDLE;
			grp_q       <= '0;
			bit_q       <= '0;
			rv_s1       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			rv_s1 <= (em_state_q == E_READ);
			if (push) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			case (em_state_q)
				E_IDLE: begin
					if (emit_req.start) begin
						grp_q      <= gqp_pkg::GROUP_W'(gqp_pkg::ROW_BYTES - 1);
						bit_q      <= '0;
						em_state_q <= E_READ;
					end
				end
				E_READ: begin
					bit_q <= bit_q + 3'd1;
					if (bit_q == 3'd7) begin
						em_state_q <= E_WAIT;
					end
				end
				E_WAIT: em_state_q <= E_PUSH;
				E_PUSH: begin
					if (push) begin
						if (last_grp) begin
							em_state_q <= E_IDLE;
						end else begin
							grp_q      <= grp_q - gqp_pkg::GROUP_W'(1);
							bit_q      <= '0;
							em_state_q <= E_READ;
						end
					end
				end
				default: em_state_q <= E_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rin_s1  <= x_in;
		rbit_s1 <= bit_q;
		if ((em_state_q == E_IDLE) && emit_req.start) begin
			row_q    <= emit_req.row;
			thresh_q <= emit_req.thresh;
			scale_q  <= emit_req.scale;
			byte_q   <= '0;
		end else if (push) begin
			byte_q <= '0;
		end else if (rv_s1 && rin_s1 && hit) begin
			byte_q[rbit_s1] <= 1'b1;
		end
		if (push) begin
			res_q.packed_byte <= byte_q;
			res_q.last_of_row <= last_grp;
		end
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_q;

	// loads and row reads never overlap
	`GQP_ASSERT_IMPL(a_wr_when_idle, clk, arst_n, wr.en, em_state_q == E_IDLE)
	`GQP_ASSERT_NEVER(a_start_when_busy, clk, arst_n, emit_req.start && (em_state_q != E_IDLE))
	`GQP_ASSERT_IMPL(a_rd_in_range, clk, arst_n, rd_en, 32'(rd_addr) < 32'(gqp_pkg::STORE_DEPTH))

endmodule

// ----- rtl/grey_quantize_frame_bitplane_packer_top.sv -----
// ----------------------------------------------------------------------------
// grey_quantize_frame_bitplane_packer_top
// rgba pixels to quantized grey levels in a frame store, rows read back as
// 1 bpp thresholded bitplanes, last byte of the row first
// ----------------------------------------------------------------------------
//
//   channel   signals                          payload
//   request   req_valid / req_ready            req_item (mode, pixel, row, column, frame)
//   result    res_valid / res_ready            res_item (packed_byte, last_of_row)
//   config    cfg_we, cfg_index, cfg_wdata     num_frames, invert_rows
//
// a load runs the shared multiply-accumulate of the weighted squares, then
//   the root (one digit a cycle), then two divisions for the levels;
//   transparent pixels skip the first two
// an emit reads the row through the single read port of the memory, 8 reads
//   per byte for the six bytes
// one request at a time; the result register lets the block take the next
//   request while the last byte still waits
// a stalled result holds the row reader; the grey store has no reset
//
// ----------------------------------------------------------------------------
module grey_quantize_frame_bitplane_packer_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_ready,
	input  gqp_pkg::req_item_t                req_item,
	output logic                              res_valid,
	input  logic                              res_ready,
	output gqp_pkg::res_item_t                res_item,
	input  logic                              cfg_we,
	input  logic [gqp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [gqp_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_GREY = 4'b0010,
		ST_SNAP = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	state_t                       state_q;
	logic [7:0]                   num_frames_q;
	logic                         invert_rows_q;
	logic [gqp_pkg::ADDR_W-1:0]   addr_q;

	logic                         accept;
	logic                         is_load;
	logic                         row_ok;
	logic                         load_ok;
	logic                         emit_ok;
	logic [7:0]                   frames_eff;
	logic [gqp_pkg::ROW_W-1:0]    srow;
	logic [gqp_pkg::ADDR_W-1:0]   load_addr;

	logic                         grey_start;
	logic                         grey_done;
	logic [gqp_pkg::GREY_W-1:0]   grey;
	logic                         snap_start;
	logic                         snap_done;
	logic [gqp_pkg::GREY_W-1:0]   level;
	gqp_pkg::store_wr_t           store_wr;
	gqp_pkg::emit_req_t           emit_req;
	logic                         emit_done;

	// configuration registers, to be written only while idle; the block itself does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_frames_q  <= 8'd1;
			invert_rows_q <= 1'b0;
		end else if (cfg_we) begin
			case (gqp_pkg::cfg_reg_t'(cfg_index))
				gqp_pkg::REG_NUM_FRAMES:  num_frames_q  <= cfg_wdata[7:0];
				gqp_pkg::REG_INVERT_ROWS: invert_rows_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// a frame count of zero behaves as one
	assign frames_eff = (num_frames_q == 8'd0) ? 8'd1 : num_frames_q;

	// request decode
	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign is_load   = (req_item.mode == gqp_pkg::MODE_LOAD);
	assign row_ok    = 32'(req_item.row_number) < 32'(gqp_pkg::IMAGE_HEIGHT);
	assign load_ok   = row_ok
	                 && (32'(req_item.column_number) < 32'(gqp_pkg::IMAGE_WIDTH));
	// frames at or past the frame count give no bytes
	assign emit_ok   = row_ok && (req_item.frame_number < frames_eff);

	// row flip on store
	assign srow      = invert_rows_q
	                 ? gqp_pkg::ROW_W'(gqp_pkg::IMAGE_HEIGHT - 1) - req_item.row_number
	                 : req_item.row_number;
	assign load_addr = gqp_pkg::ADDR_W'(srow) * gqp_pkg::ADDR_W'(gqp_pkg::IMAGE_WIDTH)
	                 + gqp_pkg::ADDR_W'(req_item.column_number);

	assign grey_start = accept && is_load && load_ok;
	assign snap_start = (state_q == ST_GREY) && grey_done;

	// emit request toward the row reader
	always_comb begin
		emit_req.start  = accept && !is_load && emit_ok;
		emit_req.row    = req_item.row_number;
		emit_req.thresh = gqp_pkg::THRESH_W'(8'(frames_eff - req_item.frame_number))
		                * gqp_pkg::THRESH_W'(255);
		emit_req.scale  = gqp_pkg::SCALE_W'(frames_eff) + gqp_pkg::SCALE_W'(1);
	end

	// snapped level goes to the store on the snap unit's done
	always_comb begin
		store_wr.en   = (state_q == ST_SNAP) && snap_done;
		store_wr.addr = addr_q;
		store_wr.data = level;
	end

	// request sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (grey_start) begin
						state_q <= ST_GREY;
					end else if (emit_req.start) begin
						state_q <= ST_EMIT;
					end
				end
				ST_GREY: if (grey_done) state_q <= ST_SNAP;
				ST_SNAP: if (snap_done) state_q <= ST_IDLE;
				ST_EMIT: if (emit_done) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// store address of the pixel in flight
	always_ff @(posedge clk) begin
		if (grey_start) begin
			addr_q <= load_addr;
		end
	end

	gqp_grey u_grey (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (grey_start),
		.rgba   (req_item.pixel_rgba),
		.done   (grey_done),
		.grey   (grey)
	);

	gqp_snap u_snap (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (snap_start),
		.grey   (grey),
		.frames (frames_eff),
		.done   (snap_done),
		.level  (level)
	);

	gqp_row_store u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (store_wr),
		.emit_req  (emit_req),
		.emit_done (emit_done),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_item  (res_item)
	);

endmodule

// ----- bench/grey_quantize_frame_bitplane_packer_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// grey_quantize_frame_bitplane_packer_top_tb
// loads rgba pixels into the grey store and reads rows back as 1 bpp frames;
// an in-bench predictor tracks the store and the registers and every packed
// byte is compared in order, under random idling and one long output stall
// ----------------------------------------------------------------------------
module grey_quantize_frame_bitplane_packer_top_tb;

	// idle chance per cycle, in percent, on both sides
	localparam int unsigned IDLE_PCT       = 11;
	// leave room for a load still in flight
	localparam int unsigned SETTLE_CYCLES  = 120;
	// receiver hold-off for the pressure test
	localparam int unsigned STALL_CYCLES   = 300;
	// cycles with no handshake at all before the run is called dead
	localparam int unsigned WATCHDOG_LIMIT = 5000;

	// luma weights in Q16, they add up to 65536
	localparam logic [35:0] RED_WEIGHT   = 36'd19595;
	localparam logic [35:0] GREEN_WEIGHT = 36'd38470;
	localparam logic [35:0] BLUE_WEIGHT  = 36'd7471;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	gqp_pkg::req_item_t req_item;
	logic res_valid;
	logic res_ready;
	gqp_pkg::res_item_t res_item;
	logic cfg_we;
	logic [gqp_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [gqp_pkg::CFG_DATA_W-1:0] cfg_wdata;

	// predictor state: registers as last written and the quantized image
	logic [7:0] num_frames_reg;
	logic invert_reg;
	logic [7:0] grey_img [gqp_pkg::IMAGE_HEIGHT][gqp_pkg::IMAGE_WIDTH];
	bit row_written [gqp_pkg::IMAGE_HEIGHT][gqp_pkg::IMAGE_WIDTH];

	// packed bytes still owed by the block, oldest first
	gqp_pkg::res_item_t bytes_due[$];
	gqp_pkg::res_item_t want;

	int errors;
	int unsigned quiet_cycles;
	int unsigned hold_left;
	bit steady_run;
	bit stall_pending;

	grey_quantize_frame_bitplane_packer_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_item  (req_item),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_item  (res_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------

	// a frame count of zero behaves as one
	function automatic int unsigned frames_in_use();
		return (num_frames_reg == 8'd0) ? 1 : int'(num_frames_reg);
	endfunction

	// weighted root of squares; transparent pixels go white
	function automatic logic [7:0] grey_of_pixel(logic [31:0] px);
		logic [35:0] acc;
		logic [35:0] root;
		logic [35:0] trial;
		if (px[7:0] <= 8'd127)
			return 8'd255;
		acc = RED_WEIGHT * px[31:24] * px[31:24]
			+ GREEN_WEIGHT * px[23:16] * px[23:16]
			+ BLUE_WEIGHT * px[15:8] * px[15:8];
		root = '0;
		// integer root, one bit at a time from the top
		for (int b = 16; b >= 0; b--) begin
			trial = root | (36'd1 << b);
			if (trial * trial <= acc)
				root = trial;
		end
		return root[15:8];
	endfunction

	// nearer of the two neighbouring levels, ties go to the upper one
	function automatic logic [7:0] snap_level(int unsigned c, int unsigned f);
		int unsigned k;
		int unsigned lo;
		int unsigned hi;
		int unsigned v;
		k  = (c * f) / 255;
		lo = (k * 255 + f - 1) / f;
		hi = ((k + 1) * 255 + f - 1) / f;
		v  = (c - lo < hi - c) ? lo : hi;
		return (v > 255) ? 8'd255 : 8'(v);
	endfunction

	// updates the image on a load, queues the row bytes on an emit
	function automatic void track_request(gqp_pkg::req_item_t item);
		int unsigned f;
		int unsigned srow;
		int unsigned x;
		logic [7:0] bits;
		gqp_pkg::res_item_t r;
		f = frames_in_use();
		if (item.mode == gqp_pkg::MODE_LOAD) begin
			if (item.row_number >= gqp_pkg::IMAGE_HEIGHT ||
				item.column_number >= gqp_pkg::IMAGE_WIDTH)
				return;
			srow = invert_reg ? (gqp_pkg::IMAGE_HEIGHT - 1 - item.row_number)
				: item.row_number;
			grey_img[srow][item.column_number] =
				snap_level(grey_of_pixel(item.pixel_rgba), f);
			row_written[srow][item.column_number] = 1'b1;
			return;
		end
		if (item.row_number >= gqp_pkg::IMAGE_HEIGHT || item.frame_number >= f)
			return;
		// last pixel group goes out first
		for (int k = 0; k < gqp_pkg::ROW_BYTES; k++) begin
			bits = '0;
			for (int i = 0; i < 8; i++) begin
				x = (gqp_pkg::ROW_BYTES - 1 - k) * 8 + i;
				if (x < gqp_pkg::IMAGE_WIDTH &&
					grey_img[item.row_number][x] * (f + 1) <= 255 * (f - item.frame_number))
					bits[i] = 1'b1;
			end
			r.packed_byte = bits;
			r.last_of_row = (k == gqp_pkg::ROW_BYTES - 1);
			bytes_due.push_back(r);
		end
	endfunction

	// ------------------------------------------------------------------
	// request builders
	// ------------------------------------------------------------------

	function automatic logic [31:0] random_pixel();
		logic [31:0] px;
		px = $urandom;
		case ($urandom_range(7))
			0: ;                                          // anything at all
			1: px[7:0] = 8'($urandom_range(127));         // transparent
			2: px[31:8] = ($urandom_range(1) != 0) ? 24'hFFFFFF : 24'h000000;
			default: px[7:0] = 8'($urandom_range(255, 128));
		endcase
		return px;
	endfunction

	// corner pixels first, then random content
	function automatic logic [31:0] corner_pixel(int unsigned idx);
		case (idx)
			0: return 32'h0000_0000;   // transparent black reads white
			1: return 32'hFFFF_FF7F;   // alpha just under the cut
			2: return 32'h0000_0080;   // alpha just over the cut, black
			3: return 32'hFFFF_FFFF;
			4: return 32'hFF00_00FF;   // red only
			5: return 32'h00FF_00FF;   // green only
			6: return 32'h0000_FFFF;   // blue only
			7: return 32'h8080_80FF;
			8: return 32'h0101_01FF;
			9: return 32'hFEFE_FEFF;
			10: return 32'h7F7F_7F80;
			11: return 32'h0000_00FF;
			default: return random_pixel();
		endcase
	endfunction

	function automatic gqp_pkg::req_item_t load_request(int unsigned row, int unsigned col,
		logic [31:0] px);
		gqp_pkg::req_item_t item;
		item.mode          = gqp_pkg::MODE_LOAD;
		item.pixel_rgba    = px;
		item.row_number    = 5'(row);
		item.column_number = 6'(col);
		item.frame_number  = 8'($urandom);   // ignored on a load
		return item;
	endfunction

	function automatic gqp_pkg::req_item_t emit_request(int unsigned row,
		int unsigned frame);
		gqp_pkg::req_item_t item;
		item.mode          = gqp_pkg::MODE_EMIT;
		item.pixel_rgba    = $urandom;       // ignored on an emit
		item.row_number    = 5'(row);
		item.column_number = 6'($urandom);   // ignored on an emit
		item.frame_number  = 8'(frame);
		return item;
	endfunction

	// any position, columns past the image edge included
	function automatic gqp_pkg::req_item_t stray_load();
		return load_request($urandom_range(gqp_pkg::IMAGE_HEIGHT - 1), $urandom_range(63),
			random_pixel());
	endfunction

	// mostly a frame that exists, else one at or past the frame count
	function automatic int unsigned random_frame(int unsigned past_pct);
		int unsigned f;
		f = frames_in_use();
		if ($urandom_range(99) < past_pct)
			return $urandom_range(255, f);
		return $urandom_range(f - 1);
	endfunction

	// only rows with every pixel written are ever read back
	function automatic int unsigned pick_full_row();
		int unsigned full_rows[$];
		bit complete;
		for (int r = 0; r < gqp_pkg::IMAGE_HEIGHT; r++) begin
			complete = 1'b1;
			for (int c = 0; c < gqp_pkg::IMAGE_WIDTH; c++)
				if (!row_written[r][c])
					complete = 1'b0;
			if (complete)
				full_rows.push_back(r);
		end
		return full_rows[$urandom_range(full_rows.size() - 1)];
	endfunction

	// ------------------------------------------------------------------
	// drivers
	// ------------------------------------------------------------------

	// offers one request, returns at the edge that takes it; valid stays up
	// until the next negedge so back-to-back requests never drop it
	task automatic send_request(input gqp_pkg::req_item_t item);
		@(negedge clk);
		while (!steady_run && ($urandom_range(99) < IDLE_PCT)) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_item  <= item;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		track_request(item);
	endtask

	task automatic end_requests();
		@(negedge clk);
		req_valid <= 1'b0;
	endtask

	// all bytes in, then time for a load that owes nothing to finish
	task automatic settle();
		end_requests();
		while (bytes_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(negedge clk);
	endtask

	task automatic write_register(input gqp_pkg::cfg_reg_t idx, input logic [7:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == gqp_pkg::REG_NUM_FRAMES)
			num_frames_reg = value;
		else
			invert_reg = value[0];
	endtask

	// fresh content over part of a row that reads back in full
	task automatic load_random_row();
		int unsigned stored_row;
		int unsigned image_row;
		int unsigned col;
		stored_row = pick_full_row();
		image_row  = invert_reg ? (gqp_pkg::IMAGE_HEIGHT - 1 - stored_row) : stored_row;
		for (int n = 0; n < 12; n++) begin
			col = $urandom_range(gqp_pkg::IMAGE_WIDTH - 1);
			if ($urandom_range(99) < 10)
				send_request(stray_load());
			send_request(load_request(image_row, col, random_pixel()));
		end
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// 255 frames keeps every grey level; the corner pixels are thresholded at three frames
	task automatic test_grey_extremes();
		settle();
		write_register(gqp_pkg::REG_NUM_FRAMES, 8'd255);
		write_register(gqp_pkg::REG_INVERT_ROWS, 8'd0);
		for (int col = 0; col < gqp_pkg::IMAGE_WIDTH; col++)
			send_request(load_request(0, col, corner_pixel(col)));
		send_request(emit_request(0, 0));
		send_request(emit_request(0, 127));
		send_request(emit_request(0, 254));
	endtask

	// loads past the image edge and frames past the last give nothing
	task automatic test_ignored_requests();
		send_request(load_request(3, gqp_pkg::IMAGE_WIDTH, random_pixel()));
		send_request(load_request(0, 63, random_pixel()));
		send_request(load_request(31, $urandom_range(62, gqp_pkg::IMAGE_WIDTH + 1),
			random_pixel()));
		send_request(emit_request(0, 255));
		settle();
		write_register(gqp_pkg::REG_NUM_FRAMES, 8'd1);
		send_request(emit_request(0, 1));
		send_request(emit_request(0, 0));
	endtask

	// a zero frame count quantizes and thresholds like a count of one
	task automatic test_frame_count_zero();
		settle();
		write_register(gqp_pkg::REG_NUM_FRAMES, 8'd0);
		for (int col = 0; col < 8; col++)
			send_request(load_request(0, col, random_pixel()));
		send_request(emit_request(0, 0));
		send_request(emit_request(0, 1));
	endtask

	// with the flip on, image row 31 lands in stored row 0
	task automatic test_row_flip();
		settle();
		write_register(gqp_pkg::REG_NUM_FRAMES, 8'd3);
		write_register(gqp_pkg::REG_INVERT_ROWS, 8'd1);
		for (int col = 8; col < 16; col++)
			send_request(load_request(gqp_pkg::IMAGE_HEIGHT - 1, col, random_pixel()));
		send_request(load_request(0, 40, random_pixel()));
		send_request(emit_request(0, 0));
		send_request(emit_request(0, 1));
		send_request(emit_request(0, 2));
	endtask

	// receiver holds off while emits keep coming, so the block backs up
	task automatic test_output_stall();
		settle();
		write_register(gqp_pkg::REG_NUM_FRAMES, 8'd7);
		write_register(gqp_pkg::REG_INVERT_ROWS, 8'd0);
		steady_run    = 1'b1;
		stall_pending = 1'b1;
		repeat (8)
			send_request(emit_request(pick_full_row(), random_frame(0)));
		steady_run = 1'b0;
	endtask

	// rows of random content under several settings, emits in between
	task automatic test_random_traffic();
		logic [7:0] frames;
		for (int phase = 0; phase < 4; phase++) begin
			settle();
			case (phase)
				0: frames = 8'($urandom_range(254, 2));
				1: frames = 8'd1;
				2: frames = 8'd255;
				default: frames = 8'($urandom_range(16, 2));
			endcase
			write_register(gqp_pkg::REG_NUM_FRAMES, frames);
			write_register(gqp_pkg::REG_INVERT_ROWS, (phase % 2 == 0) ? 8'd1 : 8'd0);
			// one phase runs with no idling on either side
			steady_run = (phase == 2);
			if (phase % 2 == 0)
				load_random_row();
			for (int n = 0; n < 5; n++) begin
				if ($urandom_range(99) < 8)
					send_request(stray_load());
				send_request(emit_request(pick_full_row(), random_frame(15)));
			end
			steady_run = 1'b0;
		end
	endtask

	// ------------------------------------------------------------------
	// receiver, checker, watchdog
	// ------------------------------------------------------------------

	// ready drops at random, or for a whole stretch when a stall is asked
	initial begin
		res_ready = 1'b0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (stall_pending) begin
				hold_left     = STALL_CYCLES;
				stall_pending = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ready <= 1'b0;
			end else begin
				res_ready <= steady_run || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready) begin
			if (bytes_due.size() == 0) begin
				$display("%0t: unexpected byte %h last %b", $time,
					res_item.packed_byte, res_item.last_of_row);
				errors++;
			end else begin
				want = bytes_due.pop_front();
				if (res_item.packed_byte !== want.packed_byte) begin
					$display("%0t: packed_byte expected %h got %h", $time,
						want.packed_byte, res_item.packed_byte);
					errors++;
				end
				if (res_item.last_of_row !== want.last_of_row) begin
					$display("%0t: last_of_row expected %b got %b", $time,
						want.last_of_row, res_item.last_of_row);
					errors++;
				end
			end
		end
	end

	// any handshake on either channel counts as progress
	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (res_valid && res_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("CHECK FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------

	initial begin
		arst_n         = 1'b0;
		req_valid      = 1'b0;
		req_item       = '0;
		cfg_we         = 1'b0;
		cfg_index      = gqp_pkg::REG_NUM_FRAMES;
		cfg_wdata      = '0;
		errors         = 0;
		quiet_cycles   = 0;
		steady_run     = 1'b0;
		stall_pending  = 1'b0;
		// registers come out of reset at one frame, no flip
		num_frames_reg = 8'd1;
		invert_reg     = 1'b0;
		repeat (7)
			@(negedge clk);
		arst_n = 1'b1;

		test_grey_extremes();
		test_ignored_requests();
		test_frame_count_zero();
		test_row_flip();
		test_output_stall();
		test_random_traffic();

		// drain, then leave room for a stray byte to show up
		settle();
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/gqp_pkg.sv
rtl/gqp_grey.sv
rtl/gqp_div.sv
rtl/gqp_snap.sv
rtl/gqp_row_store.sv
rtl/grey_quantize_frame_bitplane_packer_top.sv
bench/grey_quantize_frame_bitplane_packer_top_tb.sv
